// ----- design/eji_pkg.sv -----
// shared types, codes and constant tables of the event jitter injector
package eji_pkg;

  // event kind codes
  localparam logic [3:0] KIND_LOAD      = 4'd0;
  localparam logic [3:0] KIND_STORE     = 4'd1;
  localparam logic [3:0] KIND_RMW       = 4'd2;
  localparam logic [3:0] KIND_LOCK0     = 4'd3;
  localparam logic [3:0] KIND_LOCK1     = 4'd4;
  localparam logic [3:0] KIND_LOCK2     = 4'd5;
  localparam logic [3:0] KIND_LOCK3     = 4'd6;
  localparam logic [3:0] KIND_UNLOCK    = 4'd7;
  localparam logic [3:0] KIND_CREATE    = 4'd8;
  localparam logic [3:0] KIND_START     = 4'd9;
  localparam logic [3:0] KIND_CONDWAIT  = 4'd10;
  localparam logic [3:0] KIND_TIMEDWAIT = 4'd11;
  localparam logic [3:0] KIND_OTHER     = 4'd12;

  // strength codes
  localparam logic [1:0] STR_NONE    = 2'd0;
  localparam logic [1:0] STR_NORMAL  = 2'd1;
  localparam logic [1:0] STR_ABOVE   = 2'd2;
  localparam logic [1:0] STR_HIGHEST = 2'd3;

  // delay kind codes
  localparam logic [1:0] DLY_NONE  = 2'd0;
  localparam logic [1:0] DLY_SPIN  = 2'd1;
  localparam logic [1:0] DLY_YIELD = 2'd2;
  localparam logic [1:0] DLY_SLEEP = 2'd3;

  // generator constants
  localparam logic [31:0] RNG_MULT = 32'd1103515245;
  localparam logic [31:0] RNG_INC  = 32'd12345;
  localparam logic [31:0] SEED_ADD = 32'd11;

  // reciprocal of 25 scaled by 2^21, rounded up; exact for 16-bit dividends
  localparam logic [16:0] RECIP_25  = 17'd83887;
  localparam int          RECIP_SHR = 21;
  localparam logic [4:0]  MOD_BASE  = 5'd25;

  // cumulative weight tables (nop, spin, yield, sleep) per strength
  localparam logic [6:0] CUM_TAB [4][4] = '{
    '{7'd100, 7'd100, 7'd100, 7'd100},
    '{7'd95,  7'd97,  7'd99,  7'd100},
    '{7'd80,  7'd90,  7'd97,  7'd100},
    '{7'd40,  7'd60,  7'd80,  7'd100}
  };

  localparam logic [4:0] MAX_COUNT = 5'd20;

  // chosen delay
  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] count;
  } delay_t;

  // (x << 16) mod 100 from m = x mod 25: equals 4 * ((9 * m) mod 25)
  function automatic logic [6:0] draw_of_mod25(input logic [4:0] m);
    logic [6:0] r;
    case (m)
      5'd0:  r = 7'd0;
      5'd1:  r = 7'd36;
      5'd2:  r = 7'd72;
      5'd3:  r = 7'd8;
      5'd4:  r = 7'd44;
      5'd5:  r = 7'd80;
      5'd6:  r = 7'd16;
      5'd7:  r = 7'd52;
      5'd8:  r = 7'd88;
      5'd9:  r = 7'd24;
      5'd10: r = 7'd60;
      5'd11: r = 7'd96;
      5'd12: r = 7'd32;
      5'd13: r = 7'd68;
      5'd14: r = 7'd4;
      5'd15: r = 7'd40;
      5'd16: r = 7'd76;
      5'd17: r = 7'd12;
      5'd18: r = 7'd48;
      5'd19: r = 7'd84;
      5'd20: r = 7'd20;
      5'd21: r = 7'd56;
      5'd22: r = 7'd92;
      5'd23: r = 7'd28;
      5'd24: r = 7'd64;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/eji_classify.sv -----
// strength picker with the previous event's kind and context
module eji_classify (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [3:0]               kind,
  input  logic [63:0]              context_req,
  output logic [1:0]               strength
);
  import eji_pkg::*;

  logic [3:0]  prev_kind;
  logic [63:0] prev_context;
  logic        same_ctx;
  logic        after_wait;

  // previous event, updated on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_kind    <= KIND_OTHER;
      prev_context <= '0;
    end else if (accept) begin
      prev_kind    <= kind;
      prev_context <= context_req;
    end
  end

  assign same_ctx   = (context_req == prev_context);
  assign after_wait = (prev_kind == KIND_CONDWAIT) || (prev_kind == KIND_TIMEDWAIT);

  // strength rules per kind
  always_comb begin
    case (kind) inside
      KIND_LOAD, KIND_STORE, KIND_RMW:
        strength = same_ctx ? STR_HIGHEST : STR_ABOVE;
      KIND_UNLOCK:
        strength = STR_NONE;
      KIND_CREATE, KIND_START:
        strength = STR_HIGHEST;
      KIND_LOCK0, KIND_LOCK1, KIND_LOCK2, KIND_LOCK3: begin
        if (after_wait) strength = STR_NONE;
        else            strength = same_ctx ? STR_ABOVE : STR_NORMAL;
      end
      KIND_CONDWAIT, KIND_TIMEDWAIT:
        strength = STR_ABOVE;
      default:
        strength = STR_NORMAL;
    endcase
  end

endmodule

// ----- design/eji_rng.sv -----
// linear congruential generator with seed reload on zero state
module eji_rng (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic        step,
  output logic [15:0] draw_bits
);
  import eji_pkg::*;

  logic [31:0] seed_load;
  logic [31:0] rng_state;
  logic [31:0] rng_base;
  logic [31:0] rng_next;

  // reload value seed*31+11 kept ready, computed at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_load <= SEED_ADD;
    end else if (seed_wr_en) begin
      seed_load <= {seed_wr_data[26:0], 5'd0} - seed_wr_data + SEED_ADD;
    end
  end

  // next state, reseeding a zero state first
  assign rng_base  = (rng_state == '0) ? seed_load : rng_state;
  assign rng_next  = rng_base * RNG_MULT + RNG_INC;
  assign draw_bits = rng_next[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= '0;
    end else if (step) begin
      rng_state <= rng_next;
    end
  end

endmodule

// ----- design/eji_split.sv -----
// draw mod 100 and split over the strength's weight table
module eji_split (
  input  logic [1:0]      strength,
  input  logic [15:0]     draw_bits,
  output eji_pkg::delay_t delay
);
  import eji_pkg::*;

  logic [32:0] prod;
  logic [11:0] quot;
  logic [16:0] quot_x25;
  logic [16:0] rem_wide;
  logic [16:0] rem_fix;
  logic [6:0]  draw;
  logic        found;
  logic [6:0]  cum;

  // draw_bits mod 25 by reciprocal multiply, then one correction step
  assign prod     = 33'(draw_bits) * 33'(RECIP_25);
  assign quot     = prod[32:RECIP_SHR];
  assign quot_x25 = {1'b0, quot, 4'd0} + {2'b0, quot, 3'd0} + {5'd0, quot};
  assign rem_wide = {1'b0, draw_bits} - quot_x25;
  assign rem_fix  = (rem_wide >= 17'(MOD_BASE)) ? rem_wide - 17'(MOD_BASE) : rem_wide;
  assign draw     = draw_of_mod25(rem_fix[4:0]);

  // first cumulative weight above the draw picks the delay
  always_comb begin
    delay = '0;
    found = 1'b0;
    cum   = '0;
    for (int i = 0; i < 4; i++) begin
      cum = CUM_TAB[strength][i];
      if (!found && draw < cum) begin
        found = 1'b1;
        if (i != 0) begin
          delay.kind  = 2'(i);
          delay.count = 5'(cum - draw);
        end
      end
    end
  end

endmodule

// ----- design/event_jitter_injector.sv -----
// an accepted request is held in the first stage register, then in the result register on the outputs
// throughput: one request per cycle, input stalls only when both stages hold unsent results
// the generator multiply sets the per-cycle path; the mod-100 split sits in the second stage
// reset (rst, synchronous): previous kind = other, previous context = 0,
// generator state = 0, seed = 0; both pipeline stages empty
module event_jitter_injector (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_wr_en,
  input  logic [31:0] seed_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  kind,
  input  logic [63:0] context_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  strength,
  output logic [1:0]  delay_kind,
  output logic [4:0]  delay_count
);
  import eji_pkg::*;

  logic        accept;
  logic [1:0]  str_now;
  logic [15:0] draw_now;
  logic        a_valid;
  logic [1:0]  a_strength;
  logic [15:0] a_bits;
  delay_t      a_delay;
  logic        out_free;
  logic        a_free;

  // handshake
  assign out_free = !out_valid || !out_stall;
  assign a_free   = !a_valid || out_free;
  assign in_stall = !a_free;
  assign accept   = in_valid && !in_stall;

  eji_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .kind        (kind),
    .context_req (context_req),
    .strength    (str_now)
  );

  eji_rng u_rng (
    .clk          (clk),
    .rst          (rst),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .step         (accept && (str_now != STR_NONE)),
    .draw_bits    (draw_now)
  );

  // first stage: strength and generator bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_strength <= str_now;
      a_bits     <= draw_now;
    end
  end

  eji_split u_split (
    .strength  (a_strength),
    .draw_bits (a_bits),
    .delay     (a_delay)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && a_valid) begin
      strength    <= a_strength;
      delay_kind  <= (a_strength == STR_NONE) ? DLY_NONE : a_delay.kind;
      delay_count <= (a_strength == STR_NONE) ? 5'd0 : a_delay.count;
    end
  end

  // checks
  a_none_no_delay: assert property (@(posedge clk) disable iff (rst)
    out_valid && (strength == STR_NONE) |-> (delay_kind == DLY_NONE))
    else $error("strength none with a delay");

  a_count_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((delay_kind == DLY_NONE) == (delay_count == 5'd0)))
    else $error("delay count disagrees with delay kind");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delay_count <= MAX_COUNT))
    else $error("delay count out of range");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (a_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule
